// ----- rtl/cfks_pkg.sv -----
// Shared operation codes, status codes and result record for the key-search FIFO.
package cfks_pkg;

   typedef logic [1:0] op_type;
   typedef logic [1:0] status_type;

   localparam op_type OP_ENQUEUE = 2'd0;
   localparam op_type OP_DEQUEUE = 2'd1;
   localparam op_type OP_SEARCH  = 2'd2;

   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

   typedef struct packed {
      status_type status;
      logic       found;
      logic [2:0] position;
      logic [3:0] level;
      logic       is_empty;
      logic       is_full;
   } result_type;

endpackage

// ----- rtl/cfks_store.sv -----
// Entry memory with one write port and one registered read port.
module cfks_store import cfks_pkg::*; #(
   parameter int DEPTH = 8,
   localparam int SW = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [SW-1:0]       wr_addr,
   input  logic signed [31:0]  wr_data,
   input  logic [SW-1:0]       rd_addr,
   output logic signed [31:0]  rd_data
);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/cfks_ctrl.sv -----
// Sequencer with head, tail and occupancy pointers and the shared key comparator.
module cfks_ctrl import cfks_pkg::*; #(
   parameter int DEPTH = 8,
   localparam int SW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  op_type             req_operation,
   input  logic signed [31:0] req_value,
   output logic               wr_en,
   output logic [SW-1:0]      wr_addr,
   output logic signed [31:0] wr_data,
   output logic [SW-1:0]      rd_addr,
   input  logic signed [31:0] rd_data,
   output logic               res_valid,
   input  logic               res_ready,
   output result_type         res
);

   localparam int PW = (SW > 3) ? SW : 3;
   localparam int LW = (CW > 4) ? CW : 4;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESP} state_type;

   state_type          state_ff;
   logic [SW-1:0]      head_ff;
   logic [SW-1:0]      tail_ff;
   logic [CW-1:0]      occ_ff;
   logic [SW-1:0]      cmp_slot_ff;
   logic [CW-1:0]      cmp_cnt_ff;
   logic signed [31:0] key_ff;
   status_type         status_ff;
   logic               found_ff;
   logic [SW-1:0]      pos_ff;

   logic               accept;
   logic               is_full;
   logic               is_empty;
   logic               match;
   logic               last;
   logic [PW-1:0]      pos_ext;
   logic [LW-1:0]      level_ext;

   function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
      return (s == SW'(DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   always_comb begin
      req_ready = (state_ff == S_IDLE);
      accept    = req_valid && req_ready;
      is_full   = (occ_ff == CW'(DEPTH));
      is_empty  = (occ_ff == '0);
      wr_en     = accept && (req_operation == OP_ENQUEUE) && !is_full;
      wr_addr   = tail_ff;
      wr_data   = req_value;
      rd_addr   = (state_ff == S_SCAN) ? next_slot(cmp_slot_ff) : head_ff;
      match     = (rd_data == key_ff);
      last      = (CW'(cmp_cnt_ff + 1'b1) == occ_ff);
      pos_ext   = PW'(pos_ff);
      level_ext = LW'(occ_ff);
      res_valid = (state_ff == S_RESP);
      res.status   = status_ff;
      res.found    = found_ff;
      res.position = pos_ext[2:0];
      res.level    = level_ext[3:0];
      res.is_empty = is_empty;
      res.is_full  = is_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  key_ff    <= req_value;
                  found_ff  <= 1'b0;
                  pos_ff    <= '0;
                  unique case (req_operation)
                     OP_ENQUEUE: begin
                        state_ff <= S_RESP;
                        if (is_full) begin
                           status_ff <= ST_FULL;
                        end else begin
                           status_ff <= ST_DONE;
                           tail_ff   <= next_slot(tail_ff);
                           occ_ff    <= occ_ff + 1'b1;
                        end
                     end
                     OP_DEQUEUE: begin
                        state_ff <= S_RESP;
                        if (is_empty) begin
                           status_ff <= ST_EMPTY;
                        end else begin
                           status_ff <= ST_DONE;
                           head_ff   <= next_slot(head_ff);
                           occ_ff    <= occ_ff - 1'b1;
                        end
                     end
                     OP_SEARCH: begin
                        status_ff <= ST_DONE;
                        if (!is_empty) begin
                           cmp_slot_ff <= head_ff;
                           cmp_cnt_ff  <= '0;
                           state_ff    <= S_SCAN;
                        end else begin
                           state_ff    <= S_RESP;
                        end
                     end
                     default: begin
                        status_ff <= ST_DONE;
                        state_ff  <= S_RESP;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (match) begin
                  found_ff <= 1'b1;
                  pos_ff   <= cmp_slot_ff;
                  state_ff <= S_RESP;
               end else if (last) begin
                  state_ff <= S_RESP;
               end else begin
                  cmp_slot_ff <= next_slot(cmp_slot_ff);
                  cmp_cnt_ff  <= cmp_cnt_ff + 1'b1;
               end
            end
            S_RESP: begin
               if (res_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- rtl/circular_fifo_with_key_search.sv -----
// Top level of the ring-buffer FIFO with key search and its result register.
//
// The req channel carries one operation per beat: enqueue a word at the tail,
// dequeue the head, or search the held entries from head to tail for a key.
// Every req beat yields exactly one rsp beat with the status, the search hit
// and slot, and the fill level with its empty and full flags.
// Only one operation is in flight at a time, and req_ready is high only while
// the sequencer is idle.
// Enqueue and dequeue pass through the response state into the rsp register.
// A search compares one stored entry per cycle through the single comparator
// and the registered memory read port, and stops at the first hit or last entry.
// The rsp outputs come from a register, so the next req beat can be accepted
// while a result still waits; a stalled receiver holds the sequencer only
// once a second result is ready.
// Reset empties the queue and clears both pointers; the entry memory is not
// cleared, since only written slots are ever compared.
module circular_fifo_with_key_search import cfks_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic               rsp_found,
   output logic [2:0]         rsp_position,
   output logic [3:0]         rsp_level,
   output logic               rsp_is_empty,
   output logic               rsp_is_full
);

   localparam int SW = $clog2(DEPTH);

   logic               wr_en;
   logic [SW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic [SW-1:0]      rd_addr;
   logic signed [31:0] rd_data;
   logic               res_valid;
   logic               res_ready;
   result_type         res;
   logic               rsp_valid_ff;
   result_type         rsp_ff;

   cfks_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_value     (req_value),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res)
   );

   cfks_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_ff.status;
   assign rsp_found    = rsp_ff.found;
   assign rsp_position = rsp_ff.position;
   assign rsp_level    = rsp_ff.level;
   assign rsp_is_empty = rsp_ff.is_empty;
   assign rsp_is_full  = rsp_ff.is_full;

endmodule
